[rtl/mata_pkg.sv]
// ----------------------------------------------------------------------------
// mata_pkg: shared types and constants for the aftertouch aggregator
// Holds the request and mode codes, the MIDI status values and the
// controller types that the sequencer and the peak unit use.
// ----------------------------------------------------------------------------
package mata_pkg;

  localparam int DATA_W = 7;

  // request codes
  localparam logic [1:0] ACT_NOTE_ON     = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF    = 2'd1;
  localparam logic [1:0] ACT_KEY_PRESS   = 2'd2;
  localparam logic [1:0] ACT_RELEASE_ALL = 2'd3;

  // pressure modes
  localparam logic [1:0] MODE_POLY = 2'd0;
  localparam logic [1:0] MODE_CHAN = 2'd1;

  // configuration register indexes
  localparam logic REG_PRESSURE_MODE  = 1'b0;
  localparam logic REG_CHANNEL_NUMBER = 1'b1;

  // MIDI status bytes, channel ored in later
  localparam logic [7:0] ST_NOTE_ON = 8'h90;
  localparam logic [7:0] ST_POLY_AT = 8'hA0;
  localparam logic [7:0] ST_CHAN_AT = 8'hD0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } peak_ctrl_t;

endpackage

[rtl/mata_ram.sv]
// ----------------------------------------------------------------------------
// mata_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in
// the cycle after the read enable.
// ----------------------------------------------------------------------------
module mata_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mata_peak.sv]
// ----------------------------------------------------------------------------
// mata_peak: running maximum unit
// One comparator reused once per table entry; clear restarts the maximum.
// ----------------------------------------------------------------------------
module mata_peak (
  input  logic                        clk,
  input  mata_pkg::peak_ctrl_t        ctrl,
  input  logic [mata_pkg::DATA_W-1:0] sample,
  output logic [mata_pkg::DATA_W-1:0] peak
);
  import mata_pkg::*;

  logic [DATA_W-1:0] peak_next;

  always_comb begin
    peak_next = peak;
    if (ctrl.clear) begin
      peak_next = '0;
    end else if (ctrl.step && (sample > peak)) begin
      peak_next = sample;
    end
  end

  always_ff @(posedge clk) begin
    peak <= peak_next;
  end

endmodule

[rtl/midi_aftertouch_aggregator.sv]
// ----------------------------------------------------------------------------
// midi_aftertouch_aggregator: MIDI note and aftertouch message former
// Turns note and pressure requests into MIDI messages on the configured
// channel, keeping a per-note pressure table for channel aftertouch.
// ----------------------------------------------------------------------------
// Note on, note off, polyphonic key pressure and release all need no scan:
// the request is accepted and its message sits in the output register from
// the next cycle on (release all sends one only in channel mode). A key
// pressure in channel mode scans the table: the table RAM is read one entry
// per cycle through its single read port and every entry goes through the
// one shared max comparator. in_ready is low during the scan and while an
// undelivered message blocks the output register. The table needs no
// clearing pass after reset: a valid bit per entry makes unwritten entries
// read as zero, and release all drops every valid bit at once.
// ----------------------------------------------------------------------------
module midi_aftertouch_aggregator #(
  parameter int NOTE_COUNT = 128
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [6:0] note_number,
  input  logic [6:0] amount,
  // message channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] status_byte,
  output logic [6:0] first_data,
  output logic [6:0] second_data
);
  import mata_pkg::*;

  localparam int         NOTE_AW    = $clog2(NOTE_COUNT);
  localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);
  localparam logic [NOTE_AW-1:0] LAST_ADDR = NOTE_AW'(NOTE_COUNT - 1);

  // configuration registers
  logic [1:0] pressure_mode;
  logic [3:0] channel_number;

  // sequencer
  state_t state, state_next;
  logic [NOTE_AW-1:0] scan_addr;
  logic rd_live;     // RAM read data of the previous cycle is a table entry
  logic rd_valid;    // that entry has been written since the last clear

  logic [NOTE_COUNT-1:0] note_valid;
  logic [DATA_W-1:0] sent_channel_pressure;

  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] peak;
  logic [DATA_W-1:0] sample;
  peak_ctrl_t peak_ctrl;

  logic accept;
  logic in_range;
  logic start_scan;
  logic ram_we;
  logic ram_re;
  logic clear_all;
  logic sent_load;
  logic res_load;
  logic [7:0] res_status;
  logic [6:0] res_first;
  logic [6:0] res_second;

  assign accept   = in_valid && in_ready;
  assign in_range = {1'b0, note_number} < NOTE_LIMIT;
  assign start_scan = (action == ACT_KEY_PRESS) && in_range && (pressure_mode == MODE_CHAN);

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_mode  <= MODE_POLY;
      channel_number <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESSURE_MODE:  pressure_mode  <= cfg_data[1:0];
        REG_CHANNEL_NUMBER: channel_number <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && start_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_addr == LAST_ADDR) begin
          state_next = S_LAST;
        end
      end
      S_LAST:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    clear_all       = 1'b0;
    sent_load       = 1'b0;
    res_load        = 1'b0;
    res_status      = ST_NOTE_ON;
    res_first       = note_number;
    res_second      = amount;
    peak_ctrl.clear = 1'b0;
    peak_ctrl.step  = rd_live;
    case (state)
      S_IDLE: begin
        // take a request only when its message has a free output slot
        in_ready = !out_valid || out_ready;
        if (accept) begin
          case (action)
            ACT_NOTE_ON: begin
              res_load = 1'b1;
            end
            ACT_NOTE_OFF: begin
              res_load   = 1'b1;
              res_second = '0;
            end
            ACT_KEY_PRESS: begin
              ram_we          = in_range;
              peak_ctrl.clear = 1'b1;
              if (in_range && (pressure_mode == MODE_POLY)) begin
                res_load   = 1'b1;
                res_status = ST_POLY_AT;
              end
            end
            ACT_RELEASE_ALL: begin
              clear_all = 1'b1;
              if (pressure_mode == MODE_CHAN) begin
                res_load   = 1'b1;
                res_status = ST_CHAN_AT;
                res_first  = '0;
                res_second = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
      end
      S_LAST: ;
      S_DONE: begin
        // send channel pressure only when the maximum moved
        if (peak != sent_channel_pressure) begin
          sent_load  = 1'b1;
          res_load   = 1'b1;
          res_status = ST_CHAN_AT;
          res_first  = peak;
          res_second = '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // scan address, read tracking, valid bits, last sent pressure
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      rd_live    <= 1'b0;
      note_valid <= '0;
      sent_channel_pressure <= '0;
    end else begin
      rd_live <= ram_re;
      if (state == S_SCAN) begin
        scan_addr <= scan_addr + NOTE_AW'(1);
      end else begin
        scan_addr <= '0;
      end
      if (clear_all) begin
        note_valid <= '0;
        sent_channel_pressure <= '0;
      end else begin
        if (ram_we) begin
          note_valid[note_number[NOTE_AW-1:0]] <= 1'b1;
        end
        if (sent_load) begin
          sent_channel_pressure <= peak;
        end
      end
    end
  end

  // sample the valid bit alongside the RAM read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid <= note_valid[scan_addr];
    end
  end

  assign sample = rd_valid ? ram_rdata : '0;

  mata_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NOTE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(note_number[NOTE_AW-1:0]),
    .wdata(amount),
    .re   (ram_re),
    .raddr(scan_addr),
    .rdata(ram_rdata)
  );

  mata_peak u_peak (
    .clk   (clk),
    .ctrl  (peak_ctrl),
    .sample(sample),
    .peak  (peak)
  );

  // ---------------------------------------------------------------------------
  // output register: hold the message until it is taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_byte <= res_status | {4'b0000, channel_number};
      first_data  <= res_first;
      second_data <= res_second;
    end
  end

`ifndef SYNTH
  // the scan result never lands on top of an undelivered message
  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && sent_load |-> !out_valid)
    else $error("channel pressure loaded while output register full");

  // a channel-mode key pressure starts a scan on the next cycle
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept && start_scan |=> (state == S_SCAN) && (scan_addr == '0))
    else $error("scan did not start after channel-mode key pressure");

  // read data is only consumed right after a scan read
  a_live_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> (state == S_SCAN) || (state == S_LAST))
    else $error("table read data live outside the scan");

  // last sent pressure moves only at the end of a scan or on release all
  a_sent_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(sent_channel_pressure) |->
      $past(rst) || ($past(state) == S_DONE) || $past(clear_all))
    else $error("last sent channel pressure changed unexpectedly");
`endif

endmodule
